// ===== sv/ipv4hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hrc_pkg
// Shared types and constants for the IPv4 header receive check.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hrc_pkg;

  localparam int MAX_HEADER_BYTES = 60;

  localparam logic [3:0]  IP_VERSION      = 4'd4;
  localparam logic [3:0]  MIN_IHL         = 4'd5;
  localparam logic [5:0]  POS_TTL         = 6'd8;
  localparam logic [5:0]  POS_DEST_FIRST  = 6'd16;
  localparam logic [5:0]  POS_DEST_LAST   = 6'd19;
  localparam logic [31:0] BROADCAST_ADDR  = 32'hffff_ffff;
  localparam logic [15:0] CHECKSUM_GOOD   = 16'hffff;
  localparam logic [6:0]  MAX_HDR_BYTES_W = 7'(MAX_HEADER_BYTES);

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_HEADLEN  = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_DEST     = 3'd4,
    VERDICT_CHECKSUM = 3'd5
  } verdict_t;

endpackage

`default_nettype wire

// ===== sv/ipv4_header_receive_check.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_receive_check
// Byte-serial IPv4 header validation: version, header length, TTL,
// destination and header checksum, one verdict per packet.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        receive    in_valid/in_ready    data_byte[7:0], start_of_packet
//  out       send       out_valid/out_ready  verdict[2:0]
//  cfg       receive    cfg_write            cfg_data[31:0] (local address)
//
//  One byte per cycle while no verdict waits unaccepted; the byte that
//  decides a verdict passes the input register, then the result register.
//  The input register holds while a verdict waits unaccepted; with the
//  result side ready, a byte is taken every cycle.
//  Reset leaves the block idle until a start-of-packet byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_receive_check
  import ipv4hrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_packet,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [2:0]  verdict
);

  logic [31:0] local_address;

  logic        s_valid;
  logic [7:0]  s_data;
  logic        s_start;

  logic [5:0]  byte_position;
  logic [3:0]  header_words;
  logic [20:0] sum_accumulator;
  logic [7:0]  pending_high_byte;
  logic [31:0] destination_shift;
  logic        verdict_given;

  verdict_t    out_verdict;

  logic        advance;
  logic        update;
  logic [5:0]  p;
  logic [3:0]  hw;
  logic [20:0] sum;
  logic [7:0]  pend;
  logic [31:0] dshift;

  logic [5:0]  byte_position_next;
  logic [3:0]  header_words_next;
  logic [20:0] sum_accumulator_next;
  logic [7:0]  pending_high_byte_next;
  logic [31:0] destination_shift_next;
  logic [6:0]  hdr_bytes;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        done;
  verdict_t    v;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s_valid || advance;
  assign update   = s_valid && advance && (s_start || !verdict_given);

  always_comb begin
    p      = s_start ? '0 : byte_position;
    hw     = s_start ? '0 : header_words;
    sum    = s_start ? '0 : sum_accumulator;
    pend   = s_start ? '0 : pending_high_byte;
    dshift = s_start ? '0 : destination_shift;

    pending_high_byte_next = pend;
    sum_accumulator_next   = sum;
    if (!p[0]) begin
      pending_high_byte_next = s_data;
    end else begin
      sum_accumulator_next = sum + {5'd0, pend, s_data};
    end

    destination_shift_next = dshift;
    if (p >= POS_DEST_FIRST && p <= POS_DEST_LAST) begin
      destination_shift_next = {dshift[23:0], s_data};
    end

    header_words_next = hw;
    done = 1'b0;
    v    = VERDICT_ACCEPT;
    if (p == '0) begin
      header_words_next = s_data[3:0];
      if (s_data[7:4] != IP_VERSION) begin
        v    = VERDICT_VERSION;
        done = 1'b1;
      end else if (s_data[3:0] < MIN_IHL ||
                   {1'b0, s_data[3:0], 2'b00} > MAX_HDR_BYTES_W) begin
        v    = VERDICT_HEADLEN;
        done = 1'b1;
      end
    end else if (p == POS_TTL) begin
      if (s_data == '0) begin
        v    = VERDICT_TTL;
        done = 1'b1;
      end
    end

    hdr_bytes = {1'b0, header_words_next, 2'b00};
    fold1     = {1'b0, sum_accumulator_next[15:0]} + {12'd0, sum_accumulator_next[20:16]};
    fold2     = fold1[15:0] + {15'd0, fold1[16]};

    if (!done && p == POS_DEST_LAST) begin
      if (destination_shift_next != local_address &&
          destination_shift_next != BROADCAST_ADDR) begin
        v    = VERDICT_DEST;
        done = 1'b1;
      end
    end

    if (!done && p >= POS_DEST_LAST && ({1'b0, p} + 7'd1) == hdr_bytes) begin
      v    = (fold2 == CHECKSUM_GOOD) ? VERDICT_ACCEPT : VERDICT_CHECKSUM;
      done = 1'b1;
    end

    byte_position_next = p + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_write) begin
      local_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data  <= data_byte;
      s_start <= start_of_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      verdict_given <= 1'b1;
    end else if (update) begin
      byte_position <= byte_position_next;
      verdict_given <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      header_words      <= header_words_next;
      sum_accumulator   <= sum_accumulator_next;
      pending_high_byte <= pending_high_byte_next;
      destination_shift <= destination_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= update && done;
    end
  end

  always_ff @(posedge clk) begin
    if (update && done) begin
      out_verdict <= v;
    end
  end

  assign verdict = out_verdict;

endmodule

`default_nettype wire
